FILE: rtl/lcb_pkg.sv
// ----------------------------------------------------------------------------
// lcb_pkg: shared types and constants for the bisection line clipper
// Coordinate width, lane count, channel structs and register indexes.
// ----------------------------------------------------------------------------
package lcb_pkg;

	localparam int MaxCoords = 4;
	localparam int CoordBits = 16;

	typedef enum logic [2:0] {
		REG_X_MIN  = 3'd0,
		REG_X_MAX  = 3'd1,
		REG_Y_MIN  = 3'd2,
		REG_Y_MAX  = 3'd3,
		REG_NCOORD = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic               func;
		logic signed [15:0] first_c0;
		logic signed [15:0] first_c1;
		logic signed [15:0] first_c2;
		logic signed [15:0] first_c3;
		logic signed [15:0] second_c0;
		logic signed [15:0] second_c1;
		logic signed [15:0] second_c2;
		logic signed [15:0] second_c3;
	} in_item_t;

	typedef struct packed {
		logic               visible;
		logic               first_moved;
		logic signed [15:0] out_first_c0;
		logic signed [15:0] out_first_c1;
		logic signed [15:0] out_first_c2;
		logic signed [15:0] out_first_c3;
		logic signed [15:0] out_second_c0;
		logic signed [15:0] out_second_c1;
		logic signed [15:0] out_second_c2;
		logic signed [15:0] out_second_c3;
	} out_item_t;

	// per-step control from the sequencer to every lane
	typedef struct packed {
		logic load;    // take endpoints
		logic init;    // l <= lo, r <= hi, m <= start
		logic step;    // m <= floor((l+r)/2)
		logic go_l;    // l <= m
		logic go_r;    // r <= m
		logic wr_mn;   // low end <= m
		logic wr_mx;   // high end <= m
		logic start_hi; // start at high end
	} lane_ctl_t;

endpackage

FILE: rtl/lcb_lane.sv
// ----------------------------------------------------------------------------
// lcb_lane: one coordinate lane
// Holds both endpoints and the bisection interval for one coordinate and
// averages them with its own adder; all lanes step together on one control.
// ----------------------------------------------------------------------------
module lcb_lane #(
	parameter int W = lcb_pkg::CoordBits
) (
	input  logic                 clk,
	input  lcb_pkg::lane_ctl_t   ctl,
	input  logic signed [W-1:0]  a_in,    // low end on load
	input  logic signed [W-1:0]  b_in,    // high end on load
	output logic signed [W-1:0]  mn,
	output logic signed [W-1:0]  mx,
	output logic signed [W-1:0]  mid
);
	import lcb_pkg::*;

	logic signed [W-1:0] mn_q, mx_q, l_q, r_q, m_q;
	logic signed [W:0]   sum;

	assign sum = {l_q[W-1], l_q} + {r_q[W-1], r_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mn_q <= a_in;
			mx_q <= b_in;
		end else begin
			if (ctl.wr_mn) mn_q <= m_q;
			if (ctl.wr_mx) mx_q <= m_q;
		end
		if (ctl.init) begin
			l_q <= mn_q;
			r_q <= mx_q;
			m_q <= ctl.start_hi ? mx_q : mn_q;
		end else begin
			if (ctl.step) m_q <= sum[W:1];
			if (ctl.go_l) l_q <= m_q;
			if (ctl.go_r) r_q <= m_q;
		end
	end

	assign mn  = mn_q;
	assign mx  = mx_q;
	assign mid = m_q;

endmodule

FILE: rtl/lcb_seq.sv
// ----------------------------------------------------------------------------
// lcb_seq: clip sequencer
// Latches the end order, checks rejection, runs the low-end and high-end
// bisections over the lane row and flags the result valid, visible and moved.
// ----------------------------------------------------------------------------
module lcb_seq #(
	parameter int W = lcb_pkg::CoordBits
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                swap,
	input  logic signed [W-1:0] bmin,
	input  logic signed [W-1:0] bmax,
	input  logic signed [W-1:0] ax_mn,
	input  logic signed [W-1:0] ax_mx,
	input  logic signed [W-1:0] ax_mid,
	input  logic                res_take,
	output lcb_pkg::lane_ctl_t  ctl,
	output logic                busy,
	output logic                res_valid,
	output logic                vis,
	output logic                moved
);
	import lcb_pkg::*;

	localparam int StepCap = W + 2;
	localparam int CntW = $clog2(StepCap + 1);

	typedef enum logic [2:0] {
		IDLE, CHECK, INIT, STEP, TEST, DONE
	} state_t;

	state_t          state_q;
	logic            hi_q, swap_q, vis_q, moved_q;
	logic [CntW-1:0] cnt_q;
	logic signed [W-1:0] bnd;

	assign bnd = hi_q ? bmax : bmin;

	always_comb begin
		ctl = '0;
		ctl.load = start;
		ctl.start_hi = hi_q;
		unique case (state_q)
			INIT: ctl.init = 1'b1;
			STEP: ctl.step = 1'b1;
			TEST: begin
				if (ax_mid == bnd || cnt_q == CntW'(StepCap)) begin
					ctl.wr_mn = !hi_q;
					ctl.wr_mx = hi_q;
				end else if (ax_mid < bnd) begin
					ctl.go_l = 1'b1;
				end else begin
					ctl.go_r = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			hi_q    <= 1'b0;
			swap_q  <= 1'b0;
			vis_q   <= 1'b0;
			moved_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: if (start) begin
					state_q <= CHECK;
					swap_q  <= swap;
					moved_q <= 1'b0;
				end
				CHECK: begin
					if (bmin > bmax || ax_mn >= bmax || ax_mx <= bmin) begin
						vis_q   <= 1'b0;
						state_q <= DONE;
					end else begin
						vis_q <= 1'b1;
						if (ax_mn <= bmin) begin
							hi_q <= 1'b0;
							moved_q <= !swap_q;
							state_q <= INIT;
						end else if (ax_mx >= bmax) begin
							hi_q <= 1'b1;
							moved_q <= swap_q;
							state_q <= INIT;
						end else begin
							state_q <= DONE;
						end
					end
				end
				INIT: begin
					cnt_q <= '0;
					// start point already on bound: write back unchanged
					state_q <= TEST;
				end
				STEP: begin
					cnt_q <= cnt_q + 1'b1;
					state_q <= TEST;
				end
				TEST: begin
					if (ax_mid == bnd || cnt_q == CntW'(StepCap)) begin
						if (!hi_q && ax_mx >= bmax) begin
							hi_q <= 1'b1;
							if (swap_q) moved_q <= 1'b1;
							state_q <= INIT;
						end else begin
							state_q <= DONE;
						end
					end else begin
						state_q <= STEP;
					end
				end
				DONE: if (res_take) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy      = state_q != IDLE;
	assign res_valid = state_q == DONE;
	assign vis       = vis_q;
	assign moved     = moved_q;

endmodule

FILE: rtl/line_clip_bisection.sv
// ----------------------------------------------------------------------------
// line_clip_bisection: midpoint-subdivision clipper on one axis
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_item_t
//   out      output     out_valid/out_ready  out_item_t
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction in flight. Each clipped bound runs INIT, then TEST and STEP in
// turn until the midpoint hits the bound or the step cap; a transaction also
// passes accept, check and result. Each loop step is one average-and-compare
// in the lane row. Reset clears control and loads bound defaults.
// The result is held in the lanes until out_ready; input waits meanwhile.
// ----------------------------------------------------------------------------
module line_clip_bisection (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lcb_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lcb_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import lcb_pkg::*;

	localparam int MAX_COORDS = MaxCoords;
	localparam int W = CoordBits;
	localparam int NW = $clog2(MAX_COORDS + 1);

	logic signed [W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [2:0]          ncoord_q;
	logic                func_q;
	logic [NW-1:0]       n_eff;

	logic signed [W-1:0] v1 [MAX_COORDS];
	logic signed [W-1:0] v2 [MAX_COORDS];
	logic signed [W-1:0] a_in [MAX_COORDS];
	logic signed [W-1:0] b_in [MAX_COORDS];
	logic signed [W-1:0] mn [MAX_COORDS];
	logic signed [W-1:0] mx [MAX_COORDS];
	logic signed [W-1:0] mid [MAX_COORDS];

	lane_ctl_t ctl;
	logic      start, swap, busy, vis, moved, swap_q;
	logic signed [W-1:0] bmin, bmax;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy;
	assign start     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= '0;
			x_max_q  <= W'(1023);
			y_min_q  <= '0;
			y_max_q  <= W'(1023);
			ncoord_q <= 3'd4;
			func_q   <= 1'b0;
			swap_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_X_MIN:  x_min_q  <= cfg_data[W-1:0];
					REG_X_MAX:  x_max_q  <= cfg_data[W-1:0];
					REG_Y_MIN:  y_min_q  <= cfg_data[W-1:0];
					REG_Y_MAX:  y_max_q  <= cfg_data[W-1:0];
					REG_NCOORD: ncoord_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (start) begin
				func_q <= in_data.func;
				swap_q <= swap;
			end
		end
	end

	always_comb begin
		if (ncoord_q < 3'd2) n_eff = NW'(2);
		else if (32'(ncoord_q) > MAX_COORDS) n_eff = NW'(MAX_COORDS);
		else n_eff = NW'(ncoord_q);
	end

	assign v1[0] = in_data.first_c0;
	assign v1[1] = in_data.first_c1;
	assign v1[2] = n_eff > NW'(2) ? in_data.first_c2 : '0;
	assign v1[3] = n_eff > NW'(3) ? in_data.first_c3 : '0;
	assign v2[0] = in_data.second_c0;
	assign v2[1] = in_data.second_c1;
	assign v2[2] = n_eff > NW'(2) ? in_data.second_c2 : '0;
	assign v2[3] = n_eff > NW'(3) ? in_data.second_c3 : '0;

	assign swap = in_data.func ? !(v1[1] < v2[1]) : !(v1[0] < v2[0]);
	assign bmin = func_q ? y_min_q : x_min_q;
	assign bmax = func_q ? y_max_q : x_max_q;

	for (genvar g = 0; g < MAX_COORDS; g++) begin : g_lane
		assign a_in[g] = swap ? v2[g] : v1[g];
		assign b_in[g] = swap ? v1[g] : v2[g];
		lcb_lane #(.W(W)) u_lane (
			.clk (clk),
			.ctl (ctl),
			.a_in(a_in[g]),
			.b_in(b_in[g]),
			.mn  (mn[g]),
			.mx  (mx[g]),
			.mid (mid[g])
		);
	end

	lcb_seq #(.W(W)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.swap     (swap),
		.bmin     (bmin),
		.bmax     (bmax),
		.ax_mn    (func_q ? mn[1] : mn[0]),
		.ax_mx    (func_q ? mx[1] : mx[0]),
		.ax_mid   (func_q ? mid[1] : mid[0]),
		.res_take (out_ready),
		.ctl      (ctl),
		.busy     (busy),
		.res_valid(out_valid),
		.vis      (vis),
		.moved    (moved)
	);

	always_comb begin
		out_data = '0;
		if (vis) begin
			out_data.visible       = 1'b1;
			out_data.first_moved   = moved;
			out_data.out_first_c0  = swap_q ? mx[0] : mn[0];
			out_data.out_first_c1  = swap_q ? mx[1] : mn[1];
			out_data.out_first_c2  = swap_q ? mx[2] : mn[2];
			out_data.out_first_c3  = swap_q ? mx[3] : mn[3];
			out_data.out_second_c0 = swap_q ? mn[0] : mx[0];
			out_data.out_second_c1 = swap_q ? mn[1] : mx[1];
			out_data.out_second_c2 = swap_q ? mn[2] : mx[2];
			out_data.out_second_c3 = swap_q ? mn[3] : mx[3];
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_moved_vis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.visible |-> !out_data.first_moved)
		else $error("moved on rejected segment");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("not idle after result");

endmodule
